FILE: rtl/sira_pkg.sv
// ----------------------------------------------------------------------------
// sira_pkg
// shared types, constants and helpers of the radix ascii converter
// ----------------------------------------------------------------------------
package sira_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int MAX_RADIX      = 26;
  localparam int DIGIT_DEPTH    = VALUE_WIDTH;
  localparam int DECIMAL_DIGITS = 10;

  localparam int RADIX_W = $clog2(MAX_RADIX + 1);
  localparam int DIGIT_W = RADIX_W;
  localparam int ADDR_W  = $clog2(DIGIT_DEPTH);
  localparam int CNT_W   = $clog2(DIGIT_DEPTH + 1);
  localparam int STEP_W  = $clog2(VALUE_WIDTH);

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_RADIX_LOW  = 2'd1;
  localparam logic [1:0] STATUS_RADIX_HIGH = 2'd2;

  localparam logic [6:0] CHAR_NONE  = 7'h00;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic        [7:0]             radix;
  } sira_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [1:0] status;
    logic       last;
  } sira_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_done;
    logic emit_err;
    logic emit_sign;
    logic rd_issue;
    logic emit_digit;
  } sira_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic radix_low;
    logic radix_high;
    logic step_last;
    logic more_digits;
    logic negative;
    logic digits_left;
  } sira_sts_t;

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < DIGIT_W'(DECIMAL_DIGITS)) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_A + 7'(d) - 7'(DECIMAL_DIGITS);
    end
    return c;
  endfunction

endpackage

FILE: rtl/sira_ctrl.sv
// ----------------------------------------------------------------------------
// sira_ctrl
// sequencer: base check with error emission, digit division loop, sign and digit emission
// ----------------------------------------------------------------------------
module sira_ctrl
  import sira_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sira_sts_t sts,
  output sira_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.radix_low || sts.radix_high) begin
            cmd.emit_err = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.digit_done = 1'b1;
        if (sts.more_digits) begin
          state_nxt = S_DIV;
        end else if (sts.negative) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_nxt      = sts.digits_left ? S_READ : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/sira_dp.sv
// ----------------------------------------------------------------------------
// sira_dp
// datapath: magnitude, serial divider, digit memory and output register
// ----------------------------------------------------------------------------
module sira_dp
  import sira_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sira_in_t  in_data,
  input  sira_cmd_t cmd,
  output sira_sts_t sts,
  output logic      out_valid,
  output sira_out_t out_data
);

  logic [VALUE_WIDTH-1:0] mag_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     rem_r;
  logic [STEP_W-1:0]      step_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   neg_r;
  logic [DIGIT_W-1:0]     rd_data_r;
  logic [DIGIT_W-1:0]     mem [DIGIT_DEPTH];
  logic                   out_valid_r;
  sira_out_t              out_data_r;

  logic [VALUE_WIDTH-1:0] v_u;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [RADIX_W:0]       rem_sh;
  logic [RADIX_W:0]       rem_sub;
  logic                   q_bit;
  logic [RADIX_W-1:0]     rem_nxt;
  logic [ADDR_W-1:0]      rd_addr;

  assign v_u    = in_data.value;
  assign in_neg = v_u[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~v_u) + VALUE_WIDTH'(1) : v_u;

  // one restoring division step
  assign rem_sh  = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, radix_r};
  assign q_bit   = (rem_sh >= {1'b0, radix_r});
  assign rem_nxt = q_bit ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];

  assign rd_addr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r  <= '0;
      rem_r  <= '0;
      step_r <= '0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        mag_r   <= in_mag;
        radix_r <= in_data.radix[RADIX_W-1:0];
        neg_r   <= in_neg;
        rem_r   <= '0;
        step_r  <= '0;
        cnt_r   <= '0;
      end
      if (cmd.div_step) begin
        mag_r  <= {mag_r[VALUE_WIDTH-2:0], q_bit};
        rem_r  <= rem_nxt;
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.digit_done) begin
        cnt_r  <= cnt_r + CNT_W'(1);
        rem_r  <= '0;
        step_r <= '0;
      end
      if (cmd.rd_issue) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_done) begin
      mem[cnt_r[ADDR_W-1:0]] <= rem_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_err || cmd.emit_sign || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_data_r.char_code <= CHAR_NONE;
      out_data_r.status    <= sts.radix_low ? STATUS_RADIX_LOW : STATUS_RADIX_HIGH;
      out_data_r.last      <= 1'b1;
    end else if (cmd.emit_sign) begin
      out_data_r.char_code <= CHAR_MINUS;
      out_data_r.status    <= STATUS_OK;
      out_data_r.last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_data_r.char_code <= digit_char(rd_data_r);
      out_data_r.status    <= STATUS_OK;
      out_data_r.last      <= (cnt_r == '0);
    end
  end

  assign sts.radix_low   = (in_data.radix < 8'd2);
  assign sts.radix_high  = (in_data.radix > 8'(MAX_RADIX));
  assign sts.step_last   = (step_r == STEP_W'(VALUE_WIDTH - 1));
  assign sts.more_digits = (mag_r != '0) && (cnt_r != CNT_W'(DIGIT_DEPTH - 1));
  assign sts.negative    = neg_r;
  assign sts.digits_left = (cnt_r != '0);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/signed_int_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii
// converts a signed integer to its ascii text in a base from 2 to 26
// ----------------------------------------------------------------------------
// usage
//   input channel: present in_data (value, radix) with start high; the item
//   is taken at the clock edge where start is high and busy is low
//   result channel: one ascii character per out_valid strobe, most
//   significant first, with a leading '-' for negative values; out_data.last
//   marks the final character of an item
//   a base below 2 or above 26 gives a single result with char_code 0 and a
//   nonzero status, in the cycle after the item is taken; busy stays low
// conversion
//   each digit costs one division by the base on a serial restoring divider,
//   one quotient bit per cycle, then a store of the remainder into the
//   digit memory; the sign, if any, goes out first, then each digit is read
//   from the digit memory and output; a new item is taken only when busy is low
// reset
//   synchronous active-low rst_n returns the sequencer to idle and drops
//   the strobe; the digit memory keeps its contents
// flow control
//   the receiver cannot stall: every strobe is one result, taken at once
// ----------------------------------------------------------------------------
module signed_int_to_radix_ascii
  import sira_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sira_in_t  in_data,
  output logic      out_valid,
  output sira_out_t out_data
);

  // command and status between sequencer and datapath
  sira_cmd_t cmd;
  sira_sts_t sts;

  sira_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sira_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an error result is always the only one of its item
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |-> out_data.last)
    else $error("error result without last");

  // a base below 2 answers in the next cycle with the low radix status
  a_low_radix: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.radix < 8'd2)
    |=> out_valid && (out_data.status == STATUS_RADIX_LOW))
    else $error("missing low radix error result");

  // the block frees up exactly when the final character goes out
  a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid && out_data.last)
    else $error("busy dropped without final character");

  // after the last character the block is ready again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("still busy after final character");

endmodule
